// ===== rtl/ete_pkg.sv =====
// shared types, constants and arithmetic helpers for the equatorial to horizontal transform
package ete_pkg;

   // default configuration
   localparam int ANGLE_BITS_DEFAULT    = 24;
   localparam int CORDIC_STAGES_DEFAULT = 24;

   // datapath widths: cordic x/y, rotation residual angle, product
   localparam int XW = 36;
   localparam int ZW = 34;
   localparam int PW = 34;

   // cordic gain 0.60725293 in q1.30
   localparam logic [31:0] GAIN_Q30  = 32'd652032874;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic signed [ZW-1:0] QUARTER_Z = ZW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] HALF_Z    = ZW'(64'sd2147483648);

   // atan(2^-i) in 32-bit turns
   localparam logic [31:0] ATAN_TURN [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // rotation cordic element
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   // vectoring cordic element
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic [31:0]          ang;
   } vec_type;

   // folded rotation angle
   typedef struct packed {
      logic                 flip;
      logic signed [ZW-1:0] z;
   } fold_type;

   // fold a 32-bit turn into a quarter turn either side of zero
   function automatic fold_type fold_angle(input logic [31:0] a);
      fold_type r;
      logic signed [ZW-1:0] s;
      s = ZW'($signed(a));
      r.flip = 1'b0;
      if (s > QUARTER_Z) begin
         s = s - HALF_Z;
         r.flip = 1'b1;
      end else if (s < -QUARTER_Z) begin
         s = s + HALF_Z;
         r.flip = 1'b1;
      end
      r.z = s;
      return r;
   endfunction

   // q1.30 product, floor shift by 30
   function automatic logic signed [PW-1:0] mul_q(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:30];
   endfunction

endpackage

// ===== rtl/ete_rot_cell.sv =====
// one rotation cordic cell: a fixed shift and arctangent step, registered
module ete_rot_cell #(
   parameter int IDX   = 0,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              enable,
   input  ete_pkg::rot_type  data_in,
   input  logic [TAG_W-1:0]  tag_in,
   output ete_pkg::rot_type  data_out,
   output logic [TAG_W-1:0]  tag_out
);

   ete_pkg::rot_type   data_ff, data_in_next;
   logic [TAG_W-1:0]   tag_ff;
   logic signed [ete_pkg::XW-1:0] xs, ys;
   logic signed [ete_pkg::ZW-1:0] step;

   // micro-rotation toward zero residual angle
   always_comb begin
      xs = data_in.x >>> IDX;
      ys = data_in.y >>> IDX;
      step = ete_pkg::ZW'(ete_pkg::ATAN_TURN[IDX]);
      if (data_in.z >= 0) begin
         data_in_next.x = data_in.x - ys;
         data_in_next.y = data_in.y + xs;
         data_in_next.z = data_in.z - step;
      end else begin
         data_in_next.x = data_in.x + ys;
         data_in_next.y = data_in.y - xs;
         data_in_next.z = data_in.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_next;
         tag_ff  <= tag_in;
      end
   end

   assign data_out = data_ff;
   assign tag_out  = tag_ff;

endmodule

// ===== rtl/ete_vec_cell.sv =====
// one vectoring cordic cell: drives y toward zero and sums the turned angle
module ete_vec_cell #(
   parameter int IDX   = 0,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              enable,
   input  ete_pkg::vec_type  data_in,
   input  logic [TAG_W-1:0]  tag_in,
   output ete_pkg::vec_type  data_out,
   output logic [TAG_W-1:0]  tag_out
);

   ete_pkg::vec_type   data_ff, data_in_next;
   logic [TAG_W-1:0]   tag_ff;
   logic signed [ete_pkg::XW-1:0] xs, ys;

   // micro-rotation toward the x axis
   always_comb begin
      xs = data_in.x >>> IDX;
      ys = data_in.y >>> IDX;
      if (data_in.y >= 0) begin
         data_in_next.x   = data_in.x + ys;
         data_in_next.y   = data_in.y - xs;
         data_in_next.ang = data_in.ang + ete_pkg::ATAN_TURN[IDX];
      end else begin
         data_in_next.x   = data_in.x - ys;
         data_in_next.y   = data_in.y + xs;
         data_in_next.ang = data_in.ang - ete_pkg::ATAN_TURN[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_next;
         tag_ff  <= tag_in;
      end
   end

   assign data_out = data_ff;
   assign tag_out  = tag_ff;

endmodule

// ===== rtl/equatorial_to_horizontal.sv =====
// top level: hour angle and declination to altitude and azimuth
// throughput: one beat per cycle while req_stall is low, set by the unrolled cordic cell chains
// a result stalled at the output parks in a one-beat skid register; the input stalls
// only while that register is full
// reset clears valid state and sets the observer latitude to zero
module equatorial_to_horizontal #(
   parameter int ANGLE_BITS    = ete_pkg::ANGLE_BITS_DEFAULT,
   parameter int CORDIC_STAGES = ete_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic signed [ANGLE_BITS-1:0] csr_observer_latitude,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ANGLE_BITS-1:0]        req_hour_angle,
   input  logic signed [ANGLE_BITS-1:0] req_declination,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ANGLE_BITS-1:0] rsp_altitude,
   output logic [ANGLE_BITS-1:0]        rsp_azimuth
);

   localparam int N   = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
   localparam int L   = 3 * N + 7;
   localparam int XW  = ete_pkg::XW;
   localparam int SH  = 32 - ANGLE_BITS;
   localparam logic [32:0] RND = (ANGLE_BITS < 32) ? (33'd1 << ((31 - ANGLE_BITS) & 31)) : 33'd0;
   localparam int T1W = XW + 1;
   localparam int T2W = 33;

   logic adv;
   logic [L-1:0] valid_ff;

   // latitude register
   logic [ANGLE_BITS-1:0] lat_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
      end else if (csr_valid) begin
         lat_ff <= csr_observer_latitude;
      end
   end

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[L-2:0], req_valid};
      end
   end

   // input stage: widen to 32-bit turns and fold
   ete_pkg::rot_type lat_r [0:N];
   ete_pkg::rot_type ha_r  [0:N];
   ete_pkg::rot_type dec_r [0:N];
   logic [0:0] lat_f [0:N];
   logic [0:0] ha_f  [0:N];
   logic [0:0] dec_f [0:N];
   ete_pkg::fold_type lat_fold, ha_fold, dec_fold;

   always_comb begin
      lat_fold = ete_pkg::fold_angle(32'(lat_ff) << SH);
      ha_fold  = ete_pkg::fold_angle(32'(req_hour_angle) << SH);
      dec_fold = ete_pkg::fold_angle(32'($unsigned(req_declination)) << SH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_r[0] <= '{x: XW'(ete_pkg::GAIN_Q30), y: '0, z: lat_fold.z};
         ha_r[0]  <= '{x: XW'(ete_pkg::GAIN_Q30), y: '0, z: ha_fold.z};
         dec_r[0] <= '{x: XW'(ete_pkg::GAIN_Q30), y: '0, z: dec_fold.z};
         lat_f[0] <= lat_fold.flip;
         ha_f[0]  <= ha_fold.flip;
         dec_f[0] <= dec_fold.flip;
      end
   end

   // sine/cosine cell chains, one lane per angle
   for (genvar k = 0; k < N; k++) begin : g_rot
      ete_rot_cell #(.IDX(k), .TAG_W(1)) u_lat (
         .clock(clock), .enable(adv), .data_in(lat_r[k]), .tag_in(lat_f[k]),
         .data_out(lat_r[k+1]), .tag_out(lat_f[k+1]));
      ete_rot_cell #(.IDX(k), .TAG_W(1)) u_ha (
         .clock(clock), .enable(adv), .data_in(ha_r[k]), .tag_in(ha_f[k]),
         .data_out(ha_r[k+1]), .tag_out(ha_f[k+1]));
      ete_rot_cell #(.IDX(k), .TAG_W(1)) u_dec (
         .clock(clock), .enable(adv), .data_in(dec_r[k]), .tag_in(dec_f[k]),
         .data_out(dec_r[k+1]), .tag_out(dec_f[k+1]));
   end

   // first products
   logic signed [31:0] sl, cl, sh, ch, sd, cd;
   logic signed [31:0] cdch_ff, sl_ff, cl_ff;
   logic signed [ete_pkg::PW-1:0] n1_ff, sdcl1_ff, slsd1_ff, cdch_full;

   always_comb begin
      sl = lat_f[N][0] ? -32'(lat_r[N].y) : 32'(lat_r[N].y);
      cl = lat_f[N][0] ? -32'(lat_r[N].x) : 32'(lat_r[N].x);
      sh = ha_f[N][0]  ? -32'(ha_r[N].y)  : 32'(ha_r[N].y);
      ch = ha_f[N][0]  ? -32'(ha_r[N].x)  : 32'(ha_r[N].x);
      sd = dec_f[N][0] ? -32'(dec_r[N].y) : 32'(dec_r[N].y);
      cd = dec_f[N][0] ? -32'(dec_r[N].x) : 32'(dec_r[N].x);
      cdch_full = ete_pkg::mul_q(cd, ch);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cdch_ff  <= 32'(cdch_full);
         n1_ff    <= ete_pkg::mul_q(cd, sh);
         sdcl1_ff <= ete_pkg::mul_q(sd, cl);
         slsd1_ff <= ete_pkg::mul_q(sl, sd);
         sl_ff    <= sl;
         cl_ff    <= cl;
      end
   end

   // second products
   logic signed [ete_pkg::PW-1:0] p1_ff, p2_ff, n2_ff, sdcl2_ff, slsd2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= ete_pkg::mul_q(cdch_ff, sl_ff);
         p2_ff    <= ete_pkg::mul_q(cl_ff, cdch_ff);
         n2_ff    <= n1_ff;
         sdcl2_ff <= sdcl1_ff;
         slsd2_ff <= slsd1_ff;
      end
   end

   // sums: n, d and z
   logic signed [XW-1:0] n3_ff, d3_ff, z3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         n3_ff <= XW'(n2_ff);
         d3_ff <= XW'(p1_ff) - XW'(sdcl2_ff);
         z3_ff <= XW'(slsd2_ff) + XW'(p2_ff);
      end
   end

   // azimuth vectoring: half-turn pre-rotation for a negative x
   ete_pkg::vec_type v1 [0:N];
   logic [T1W-1:0] v1_t [0:N];
   always_ff @(posedge clock) begin
      if (adv) begin
         if (d3_ff < 0) begin
            v1[0] <= '{x: -d3_ff, y: -n3_ff, ang: ete_pkg::HALF_TURN};
         end else begin
            v1[0] <= '{x: d3_ff, y: n3_ff, ang: 32'd0};
         end
         v1_t[0] <= {(n3_ff == 0) && (d3_ff == 0), z3_ff};
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_vec1
      ete_vec_cell #(.IDX(k), .TAG_W(T1W)) u_cell (
         .clock(clock), .enable(adv), .data_in(v1[k]), .tag_in(v1_t[k]),
         .data_out(v1[k+1]), .tag_out(v1_t[k+1]));
   end

   // azimuth offset and gain-corrected magnitude
   logic signed [XW+31:0] hyp_prod;
   logic                  zero1;
   logic signed [XW-1:0]  hyp_h_ff, z_h_ff;
   logic [31:0]           az_h_ff;
   always_comb begin
      zero1    = v1_t[N][T1W-1];
      hyp_prod = v1[N].x * $signed({1'b0, ete_pkg::GAIN_Q30});
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hyp_h_ff <= zero1 ? '0 : hyp_prod[XW+29:30];
         az_h_ff  <= zero1 ? 32'd0 : v1[N].ang + ete_pkg::HALF_TURN;
         z_h_ff   <= v1_t[N][XW-1:0];
      end
   end

   // altitude vectoring
   ete_pkg::vec_type v2 [0:N];
   logic [T2W-1:0] v2_t [0:N];
   always_ff @(posedge clock) begin
      if (adv) begin
         if (hyp_h_ff < 0) begin
            v2[0] <= '{x: -hyp_h_ff, y: -z_h_ff, ang: ete_pkg::HALF_TURN};
         end else begin
            v2[0] <= '{x: hyp_h_ff, y: z_h_ff, ang: 32'd0};
         end
         v2_t[0] <= {(hyp_h_ff == 0) && (z_h_ff == 0), az_h_ff};
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_vec2
      ete_vec_cell #(.IDX(k), .TAG_W(T2W)) u_cell (
         .clock(clock), .enable(adv), .data_in(v2[k]), .tag_in(v2_t[k]),
         .data_out(v2[k+1]), .tag_out(v2_t[k+1]));
   end

   // round 32-bit turns to output width
   logic [31:0]           alt32;
   logic [32:0]           alt_sum, az_sum;
   logic [ANGLE_BITS-1:0] alt_pipe, az_pipe;
   always_comb begin
      alt32    = v2_t[N][T2W-1] ? 32'd0 : v2[N].ang;
      alt_sum  = {1'b0, alt32} + RND;
      az_sum   = {1'b0, v2_t[N][31:0]} + RND;
      alt_pipe = alt_sum[SH +: ANGLE_BITS];
      az_pipe  = az_sum[SH +: ANGLE_BITS];
   end

   // output register with one-beat skid
   logic                  out_valid_ff, skid_valid_ff, out_free, pipe_valid;
   logic [ANGLE_BITS-1:0] out_alt_ff, out_az_ff, skid_alt_ff, skid_az_ff;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign adv        = !skid_valid_ff;
   assign pipe_valid = valid_ff[L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || pipe_valid;
         skid_valid_ff <= 1'b0;
      end else if (pipe_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_alt_ff <= skid_alt_ff;
            out_az_ff  <= skid_az_ff;
         end else begin
            out_alt_ff <= alt_pipe;
            out_az_ff  <= az_pipe;
         end
      end else if (adv) begin
         skid_alt_ff <= alt_pipe;
         skid_az_ff  <= az_pipe;
      end
   end

   assign req_stall    = skid_valid_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_altitude = $signed(out_alt_ff);
   assign rsp_azimuth  = out_az_ff;

endmodule
